>>> design/stok_pkg.sv
`timescale 1ns / 1ps

package stok_pkg;

  localparam int MaxResults = 3;

  // token kinds
  localparam logic [2:0] TkInt    = 3'd0;
  localparam logic [2:0] TkFloat  = 3'd1;
  localparam logic [2:0] TkIdent  = 3'd2;
  localparam logic [2:0] TkString = 3'd3;
  localparam logic [2:0] TkOper   = 3'd4;
  localparam logic [2:0] TkLparen = 3'd5;
  localparam logic [2:0] TkRparen = 3'd6;
  localparam logic [2:0] TkEnd    = 3'd7;

  // operator codes
  localparam logic [2:0] OpPlus   = 3'd0;
  localparam logic [2:0] OpMinus  = 3'd1;
  localparam logic [2:0] OpStar   = 3'd2;
  localparam logic [2:0] OpSlash  = 3'd3;
  localparam logic [2:0] OpAssign = 3'd4;
  localparam logic [2:0] OpEqual  = 3'd5;

  // event kinds
  localparam logic EvContent = 1'b0;
  localparam logic EvDone    = 1'b1;

  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7a;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5a;
  localparam logic [7:0] ChUnder  = 8'h5f;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChEq     = 8'h3d;
  localparam logic [7:0] ChLpar   = 8'h28;
  localparam logic [7:0] ChRpar   = 8'h29;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChLowN   = 8'h6e;
  localparam logic [7:0] ChLowR   = 8'h72;

  typedef struct packed {
    logic        event_kind;
    logic [2:0]  token_kind;
    logic [7:0]  char_value;
    logic [2:0]  operator_code;
    logic [31:0] int_part;
    logic [31:0] frac_part;
    logic [7:0]  frac_digits;
    logic [31:0] token_line;
  } res_t;

  function automatic res_t mk_res(input logic ev, input logic [2:0] tk,
                                  input logic [7:0] ch, input logic [2:0] op,
                                  input logic [31:0] ip, input logic [31:0] fp,
                                  input logic [7:0] fd, input logic [31:0] ln);
    res_t r;
    r.event_kind    = ev;
    r.token_kind    = tk;
    r.char_value    = ch;
    r.operator_code = op;
    r.int_part      = ip;
    r.frac_part     = fp;
    r.frac_digits   = fd;
    r.token_line    = ln;
    return r;
  endfunction

endpackage

>>> design/stok_step.sv
`timescale 1ns / 1ps

module stok_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          char_in,
  input  logic                end_of_input,
  output stok_pkg::res_t      res [stok_pkg::MaxResults],
  output logic [1:0]          res_cnt
);

  localparam logic [2:0] ModeIdle   = 3'd0;
  localparam logic [2:0] ModeInt    = 3'd1;
  localparam logic [2:0] ModeFloat  = 3'd2;
  localparam logic [2:0] ModeIdent  = 3'd3;
  localparam logic [2:0] ModeString = 3'd4;
  localparam logic [2:0] ModeEq     = 3'd5;

  logic [2:0]  scan_mode, scan_mode_next;
  logic        backslash_held, backslash_held_next;
  logic [31:0] int_accum, int_accum_next;
  logic [31:0] frac_accum, frac_accum_next;
  logic [7:0]  frac_count, frac_count_next;
  logic [31:0] line_count, line_count_next;
  logic [31:0] start_line, start_line_next;

  stok_pkg::res_t r [stok_pkg::MaxResults];
  logic [1:0]  n;
  logic        flush, rescan, fall;
  logic        is_digit, is_letter;
  logic [31:0] dig;
  logic [7:0]  c;

  assign c = char_in;
  assign is_digit  = (c >= stok_pkg::ChZero) && (c <= stok_pkg::ChNine);
  assign is_letter = ((c >= stok_pkg::ChLowA) && (c <= stok_pkg::ChLowZ)) ||
                     ((c >= stok_pkg::ChUpA) && (c <= stok_pkg::ChUpZ));
  assign dig = {24'b0, 8'(c - stok_pkg::ChZero)};

  always_comb begin
    for (int i = 0; i < stok_pkg::MaxResults; i++) begin
      r[i] = '0;
    end
    n = 2'd0;
    flush = 1'b0;
    rescan = 1'b0;
    fall = 1'b0;
    scan_mode_next      = scan_mode;
    backslash_held_next = backslash_held;
    int_accum_next      = int_accum;
    frac_accum_next     = frac_accum;
    frac_count_next     = frac_count;
    line_count_next     = line_count;
    start_line_next     = start_line;

    if (end_of_input) begin
      flush = 1'b1;
    end else begin
      case (scan_mode)
        ModeInt, ModeFloat: begin
          if (c == stok_pkg::ChDot) begin
            scan_mode_next = ModeFloat;
          end else if (is_digit) begin
            if (scan_mode == ModeFloat) begin
              frac_accum_next = (frac_accum << 3) + (frac_accum << 1) + dig;
              if (frac_count != 8'hff) frac_count_next = frac_count + 8'd1;
            end else begin
              int_accum_next = (int_accum << 3) + (int_accum << 1) + dig;
            end
          end else begin
            flush = 1'b1;
            rescan = 1'b1;
          end
        end
        ModeIdent: begin
          if (is_letter || is_digit || c == stok_pkg::ChUnder) begin
            r[n] = stok_pkg::mk_res(stok_pkg::EvContent, stok_pkg::TkIdent, c, 3'd0,
                                    32'd0, 32'd0, 8'd0, start_line);
            n = n + 2'd1;
          end else begin
            flush = 1'b1;
            rescan = 1'b1;
          end
        end
        ModeString: begin
          fall = 1'b1;
          if (backslash_held) begin
            backslash_held_next = 1'b0;
            if (c == stok_pkg::ChLowN || c == stok_pkg::ChLowR) begin
              r[n] = stok_pkg::mk_res(stok_pkg::EvContent, stok_pkg::TkString,
                                      (c == stok_pkg::ChLowN) ? stok_pkg::ChLf
                                                              : stok_pkg::ChCr,
                                      3'd0, 32'd0, 32'd0, 8'd0, start_line);
              n = n + 2'd1;
              fall = 1'b0;
            end else begin
              r[n] = stok_pkg::mk_res(stok_pkg::EvContent, stok_pkg::TkString,
                                      stok_pkg::ChBslash, 3'd0, 32'd0, 32'd0, 8'd0,
                                      start_line);
              n = n + 2'd1;
            end
          end
          if (fall) begin
            if (c == stok_pkg::ChQuote) begin
              r[n] = stok_pkg::mk_res(stok_pkg::EvDone, stok_pkg::TkString, 8'd0, 3'd0,
                                      32'd0, 32'd0, 8'd0, start_line);
              n = n + 2'd1;
              scan_mode_next      = ModeIdle;
              backslash_held_next = 1'b0;
              int_accum_next      = 32'd0;
              frac_accum_next     = 32'd0;
              frac_count_next     = 8'd0;
            end else if (c == stok_pkg::ChBslash) begin
              backslash_held_next = 1'b1;
            end else begin
              r[n] = stok_pkg::mk_res(stok_pkg::EvContent, stok_pkg::TkString, c, 3'd0,
                                      32'd0, 32'd0, 8'd0, start_line);
              n = n + 2'd1;
            end
          end
        end
        ModeEq: begin
          if (c == stok_pkg::ChEq) begin
            r[n] = stok_pkg::mk_res(stok_pkg::EvDone, stok_pkg::TkOper, 8'd0,
                                    stok_pkg::OpEqual, 32'd0, 32'd0, 8'd0, start_line);
            n = n + 2'd1;
            scan_mode_next = ModeIdle;
          end else begin
            flush = 1'b1;
            rescan = 1'b1;
          end
        end
        default: begin
          rescan = 1'b1;
        end
      endcase
    end

    // complete the pending token from the current state
    if (flush) begin
      case (scan_mode)
        ModeInt, ModeFloat: begin
          r[n] = stok_pkg::mk_res(stok_pkg::EvDone,
                                  (scan_mode == ModeInt) ? stok_pkg::TkInt
                                                         : stok_pkg::TkFloat,
                                  8'd0, 3'd0, int_accum, frac_accum, frac_count,
                                  start_line);
          n = n + 2'd1;
        end
        ModeIdent: begin
          r[n] = stok_pkg::mk_res(stok_pkg::EvDone, stok_pkg::TkIdent, 8'd0, 3'd0,
                                  32'd0, 32'd0, 8'd0, start_line);
          n = n + 2'd1;
        end
        ModeString: begin
          if (backslash_held) begin
            r[n] = stok_pkg::mk_res(stok_pkg::EvContent, stok_pkg::TkString,
                                    stok_pkg::ChBslash, 3'd0, 32'd0, 32'd0, 8'd0,
                                    start_line);
            n = n + 2'd1;
          end
          r[n] = stok_pkg::mk_res(stok_pkg::EvDone, stok_pkg::TkString, 8'd0, 3'd0,
                                  32'd0, 32'd0, 8'd0, start_line);
          n = n + 2'd1;
        end
        ModeEq: begin
          r[n] = stok_pkg::mk_res(stok_pkg::EvDone, stok_pkg::TkOper, 8'd0,
                                  stok_pkg::OpAssign, 32'd0, 32'd0, 8'd0, start_line);
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
    end

    if (end_of_input) begin
      r[n] = stok_pkg::mk_res(stok_pkg::EvDone, stok_pkg::TkEnd, 8'd0, 3'd0,
                              32'd0, 32'd0, 8'd0, line_count);
      n = n + 2'd1;
      scan_mode_next      = ModeIdle;
      backslash_held_next = 1'b0;
      int_accum_next      = 32'd0;
      frac_accum_next     = 32'd0;
      frac_count_next     = 8'd0;
      line_count_next     = 32'd0;
      start_line_next     = 32'd0;
    end

    // scan this byte from idle; a new token starts on the current line
    if (rescan) begin
      scan_mode_next      = ModeIdle;
      backslash_held_next = 1'b0;
      int_accum_next      = 32'd0;
      frac_accum_next     = 32'd0;
      frac_count_next     = 8'd0;
      start_line_next     = line_count;
      if (is_digit) begin
        scan_mode_next = ModeInt;
        int_accum_next = dig;
      end else if (is_letter) begin
        scan_mode_next = ModeIdent;
        r[n] = stok_pkg::mk_res(stok_pkg::EvContent, stok_pkg::TkIdent, c, 3'd0,
                                32'd0, 32'd0, 8'd0, line_count);
        n = n + 2'd1;
      end else if (c == stok_pkg::ChQuote) begin
        scan_mode_next = ModeString;
      end else if (c == stok_pkg::ChEq) begin
        scan_mode_next = ModeEq;
      end else if (c == stok_pkg::ChPlus || c == stok_pkg::ChMinus ||
                   c == stok_pkg::ChStar || c == stok_pkg::ChSlash) begin
        r[n] = stok_pkg::mk_res(stok_pkg::EvDone, stok_pkg::TkOper, 8'd0,
                                (c == stok_pkg::ChPlus)  ? stok_pkg::OpPlus  :
                                (c == stok_pkg::ChMinus) ? stok_pkg::OpMinus :
                                (c == stok_pkg::ChStar)  ? stok_pkg::OpStar  :
                                                           stok_pkg::OpSlash,
                                32'd0, 32'd0, 8'd0, line_count);
        n = n + 2'd1;
      end else if (c == stok_pkg::ChLpar || c == stok_pkg::ChRpar) begin
        r[n] = stok_pkg::mk_res(stok_pkg::EvDone,
                                (c == stok_pkg::ChLpar) ? stok_pkg::TkLparen
                                                        : stok_pkg::TkRparen,
                                8'd0, 3'd0, 32'd0, 32'd0, 8'd0, line_count);
        n = n + 2'd1;
      end else if (c == stok_pkg::ChLf) begin
        line_count_next = line_count + 32'd1;
      end
    end
  end

  assign res     = r;
  assign res_cnt = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= ModeIdle;
      backslash_held <= 1'b0;
      int_accum      <= 32'd0;
      frac_accum     <= 32'd0;
      frac_count     <= 8'd0;
      line_count     <= 32'd0;
      start_line     <= 32'd0;
    end else if (accept) begin
      scan_mode      <= scan_mode_next;
      backslash_held <= backslash_held_next;
      int_accum      <= int_accum_next;
      frac_accum     <= frac_accum_next;
      frac_count     <= frac_count_next;
      line_count     <= line_count_next;
      start_line     <= start_line_next;
    end
  end

endmodule

>>> design/stok_obuf.sv
`timescale 1ns / 1ps

module stok_obuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  stok_pkg::res_t ld_res [stok_pkg::MaxResults],
  input  logic [1:0]     ld_cnt,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_last,
  output stok_pkg::res_t out_res
);

  stok_pkg::res_t slot [stok_pkg::MaxResults];
  logic [1:0] cnt;
  logic [1:0] idx;

  assign out_valid = (idx != cnt);
  assign out_last  = out_valid && (2'(idx + 2'd1) == cnt);
  // the last word may leave while the next item's words load behind it
  assign in_ready  = !out_valid || (out_last && out_ready);

  always_comb begin
    case (idx)
      2'd0:    out_res = slot[0];
      2'd1:    out_res = slot[1];
      default: out_res = slot[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (load) begin
      cnt <= ld_cnt;
      idx <= 2'd0;
    end else if (out_valid && out_ready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= ld_res;
    end
  end

endmodule

>>> design/source_tokenizer_top.sv
`timescale 1ns / 1ps
// Source tokenizer: one source byte per input word, token events out.
// Input channel s_*: s_tdata is the byte, s_tuser marks end of input (byte
// ignored). Output channel m_*: one event per word, content characters of
// identifiers and strings, then a completion word per token; END after an
// end-of-input word. m_tlast flags the last event caused by one input word.
// The first event of an input word is valid in the cycle after its accept.
// Throughput: one input word per cycle while each byte yields at most one
// event and m_tready is high; a byte yielding k events (k up to 3) holds
// the input until its last event leaves the single output port, which
// drains a three-entry result buffer. A byte with no events does not stall it.
// The input is ready while the buffer is empty or its last word is leaving,
// so a stalled receiver backs up to s_tready without losing events.
// Reset (rst, synchronous) clears the scanner state, the line count and
// the result buffer. An end-of-input word also returns the scanner to its
// reset state, line count included, for the next source.
// Number completions carry integer part, fraction digits and digit count;
// the consumer forms the float value.

module source_tokenizer_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] char_in
  input  logic [0:0]   s_tuser,   // [0] end_of_input
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // [7:0] char_value, [10:8] operator_code,
                                  // [42:11] int_part, [74:43] frac_part,
                                  // [82:75] frac_digits, [114:83] token_line
  output logic [3:0]   m_tuser,   // [0] event_kind, [3:1] token_kind
  output logic         m_tlast
);

  logic           accept;
  stok_pkg::res_t step_res [stok_pkg::MaxResults];
  logic [1:0]     step_cnt;
  stok_pkg::res_t out_res;

  assign accept = s_tvalid && s_tready;

  stok_step u_step (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_in      (s_tdata),
    .end_of_input (s_tuser[0]),
    .res          (step_res),
    .res_cnt      (step_cnt)
  );

  stok_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .ld_res    (step_res),
    .ld_cnt    (step_cnt),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_last  (m_tlast),
    .out_res   (out_res)
  );

  assign m_tdata = {5'b0, out_res.token_line, out_res.frac_digits, out_res.frac_part,
                    out_res.int_part, out_res.operator_code, out_res.char_value};
  assign m_tuser = {out_res.token_kind, out_res.event_kind};

`ifndef NO_ASSERTIONS
  // a new word is only taken while the last pending event leaves
  a_accept_drained: assert property (@(posedge clk) disable iff (rst)
    (accept && m_tvalid) |-> (m_tready && m_tlast))
    else $error("input accepted while events still pending");

  // end of input always produces at least the END event
  a_eoi_emits: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser[0]) |=> m_tvalid)
    else $error("no event after end of input");

  // END is always the final event of its input word
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[3:1] == stok_pkg::TkEnd) |-> m_tlast)
    else $error("END event not flagged last");
`endif

endmodule
